### hdl/ecp_pkg.sv
// Shared types, widths and codes for the eviction candidate pool.
// No dependencies; every other file of the block imports this package.
package ecp_pkg;

   localparam int POOL_DEPTH_DEF = 16;

   localparam int KEY_W          = 32;
   localparam int DB_W           = 4;
   localparam int STAMP_W        = 24;
   localparam int EXPIRE_W       = 63;
   localparam int MINUTES_W      = 16;
   localparam int SCORE_W        = 64;
   localparam int OCC_REPORT_W   = 5;
   localparam int COUNTER_W      = 8;
   localparam int LRU_PRODUCT_W  = 40;

   localparam int POLICY_W       = 2;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int DIV_W          = 16;

   localparam logic [STAMP_W-1:0]   STAMP_MAX   = '1;
   localparam logic [MINUTES_W-1:0] MINUTE_MAX  = '1;
   localparam logic [COUNTER_W-1:0] COUNTER_MAX = '1;

   localparam logic KIND_OFFER = 1'b0;
   localparam logic KIND_TAKE  = 1'b1;

   localparam logic [POLICY_W-1:0] POLICY_LRU = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_LFU = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_TTL = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESOLUTION = 2'd2;

   localparam logic [POLICY_W-1:0]   POLICY_RESET     = POLICY_LRU;
   localparam logic [CSR_DATA_W-1:0] DECAY_RESET      = 16'd1;
   localparam logic [CSR_DATA_W-1:0] RESOLUTION_RESET = 16'd1000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCORE,
      ST_DIVIDE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic compare;
      logic insert;
      logic take;
   } pool_cmd_type;

   typedef struct packed {
      logic                    accepted;
      logic                    found;
      logic [KEY_W-1:0]        key;
      logic [DB_W-1:0]         db;
      logic [SCORE_W-1:0]      score;
      logic [OCC_REPORT_W-1:0] occupancy;
   } pool_status_type;

endpackage

### hdl/ecp_req_if.sv
// Request channel of the eviction candidate pool: valid/ready plus item fields.
// Depends on ecp_pkg for the field widths.
interface ecp_req_if;
   import ecp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [KEY_W-1:0]     key_handle;
   logic [DB_W-1:0]      db_index;
   logic [STAMP_W-1:0]   access_stamp;
   logic [EXPIRE_W-1:0]  expire_time;
   logic [STAMP_W-1:0]   clock_now;
   logic [MINUTES_W-1:0] minutes_now;

   modport source (
      output valid, kind, key_handle, db_index, access_stamp, expire_time,
             clock_now, minutes_now,
      input  ready
   );

   modport sink (
      input  valid, kind, key_handle, db_index, access_stamp, expire_time,
             clock_now, minutes_now,
      output ready
   );

endinterface

### hdl/ecp_rsp_if.sv
// Response channel of the eviction candidate pool: valid/ready plus result fields.
// Depends on ecp_pkg for the field widths.
interface ecp_rsp_if;
   import ecp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    accepted;
   logic                    found;
   logic [KEY_W-1:0]        best_key;
   logic [DB_W-1:0]         best_db;
   logic [SCORE_W-1:0]      best_score;
   logic [OCC_REPORT_W-1:0] occupancy;

   modport source (
      output valid, accepted, found, best_key, best_db, best_score, occupancy,
      input  ready
   );

   modport sink (
      input  valid, accepted, found, best_key, best_db, best_score, occupancy,
      output ready
   );

endinterface

### hdl/eviction_candidate_pool.sv
// Eviction candidate pool: keeps up to POOL_DEPTH sampled keys sorted by score
// and hands out the best one on a take item. The block works on one item at a
// time and drops ready while it does. A take item goes straight to update. An
// offer under LRU or soonest-expiry scoring passes score, compare (against all
// entries at once) and then update, which inserts it; under LFU scoring the
// decay divider, one quotient bit per cycle, runs between score and compare.
// An offer under the unused policy code goes from score to update, unstored.
// The result sits in an output register, so the next item is taken while it
// waits; an item finishing while that register is full holds until it drains.
// Depends on ecp_pkg, ecp_req_if, ecp_rsp_if, ecp_div and ecp_pool.
module eviction_candidate_pool #(
   parameter int POOL_DEPTH = ecp_pkg::POOL_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ecp_req_if.sink                         req_chan,
   ecp_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_en,
   input  logic [ecp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ecp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ecp_pkg::*;

   state_type state_ff, state_in;

   logic [POLICY_W-1:0]   policy_ff, policy_in;
   logic [CSR_DATA_W-1:0] decay_ff, decay_in;
   logic [CSR_DATA_W-1:0] resolution_ff, resolution_in;

   logic                 kind_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [DB_W-1:0]      db_ff;
   logic [STAMP_W-1:0]   stamp_ff;
   logic [EXPIRE_W-1:0]  expire_ff;
   logic [STAMP_W-1:0]   now_ff;
   logic [MINUTES_W-1:0] minutes_ff;

   logic [SCORE_W-1:0] score_ff, score_in;
   logic               score_load;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_accepted_ff;
   logic                    rsp_found_ff;
   logic [KEY_W-1:0]        rsp_key_ff;
   logic [DB_W-1:0]         rsp_db_ff;
   logic [SCORE_W-1:0]      rsp_score_ff;
   logic [OCC_REPORT_W-1:0] rsp_occ_ff;

   logic                     req_fire, slot_free, finish;
   logic                     policy_ok;
   logic [STAMP_W-1:0]       ticks;
   logic [LRU_PRODUCT_W-1:0] lru_product;
   logic [MINUTES_W-1:0]     last_minutes, elapsed;
   logic [COUNTER_W-1:0]     counter, counter_left;
   logic [DIV_W-1:0]         periods, div_quotient;
   logic                     div_start, div_done;
   logic [SCORE_W-1:0]       result_score;

   pool_cmd_type    pool_cmd;
   pool_status_type pool_status;

   // Configuration registers
   always_comb begin
      policy_in     = policy_ff;
      decay_in      = decay_ff;
      resolution_in = resolution_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_POLICY:     policy_in     = csr_data[POLICY_W-1:0];
            CSR_DECAY:      decay_in      = csr_data;
            CSR_RESOLUTION: resolution_in = csr_data;
            default:        ;
         endcase
      end
   end

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish    = (state_ff == ST_UPDATE) && slot_free;
   assign policy_ok = (policy_ff == POLICY_LRU) || (policy_ff == POLICY_LFU) ||
                      (policy_ff == POLICY_TTL);

   // LRU idle time with wrap of the 24-bit clock
   assign ticks = (now_ff >= stamp_ff) ? now_ff - stamp_ff
                                       : now_ff + (STAMP_MAX - stamp_ff);
   assign lru_product = LRU_PRODUCT_W'(ticks) * LRU_PRODUCT_W'(resolution_ff);

   // LFU minutes since last decay, wrapping at the 16-bit limit
   assign last_minutes = stamp_ff[STAMP_W-1:COUNTER_W];
   assign counter      = stamp_ff[COUNTER_W-1:0];
   assign elapsed      = (minutes_ff >= last_minutes) ? minutes_ff - last_minutes
                                                      : MINUTE_MAX - last_minutes + minutes_ff;
   assign periods      = (decay_ff == '0) ? '0 : div_quotient;
   assign counter_left = (periods > DIV_W'(counter)) ? '0
                                                     : counter - COUNTER_W'(periods);

   ecp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (elapsed),
      .divisor  (decay_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   ecp_pool #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_pool (
      .clock     (clock),
      .reset     (reset),
      .cmd       (pool_cmd),
      .new_score (score_ff),
      .new_key   (key_ff),
      .new_db    (db_ff),
      .status    (pool_status)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_chan.kind == KIND_TAKE) ? ST_UPDATE : ST_SCORE;
            end
         end
         ST_SCORE: begin
            if (policy_ff == POLICY_LFU) begin
               state_in = ST_DIVIDE;
            end else if (policy_ok) begin
               state_in = ST_COMPARE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_chan.ready   = 1'b0;
      div_start        = 1'b0;
      score_load       = 1'b0;
      score_in         = score_ff;
      pool_cmd.compare = 1'b0;
      pool_cmd.insert  = 1'b0;
      pool_cmd.take    = 1'b0;
      case (state_ff)
         ST_IDLE: req_chan.ready = 1'b1;
         ST_SCORE: begin
            score_load = 1'b1;
            case (policy_ff)
               POLICY_LRU: score_in = SCORE_W'(lru_product);
               POLICY_LFU: begin
                  div_start = 1'b1;
                  score_in  = '0;
               end
               POLICY_TTL: score_in = {1'b1, ~expire_ff};
               default:    score_in = '0;
            endcase
         end
         ST_DIVIDE: begin
            score_load = div_done;
            score_in   = SCORE_W'(COUNTER_MAX - counter_left);
         end
         ST_COMPARE: pool_cmd.compare = 1'b1;
         ST_UPDATE: begin
            pool_cmd.insert = finish && (kind_ff == KIND_OFFER) && policy_ok;
            pool_cmd.take   = finish && (kind_ff == KIND_TAKE);
         end
         default: ;
      endcase
   end

   assign result_score = (kind_ff == KIND_TAKE) ? pool_status.score : score_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         policy_ff     <= POLICY_RESET;
         decay_ff      <= DECAY_RESET;
         resolution_ff <= RESOLUTION_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         policy_ff     <= policy_in;
         decay_ff      <= decay_in;
         resolution_ff <= resolution_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Item fields, score and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff    <= req_chan.kind;
         key_ff     <= req_chan.key_handle;
         db_ff      <= req_chan.db_index;
         stamp_ff   <= req_chan.access_stamp;
         expire_ff  <= req_chan.expire_time;
         now_ff     <= req_chan.clock_now;
         minutes_ff <= req_chan.minutes_now;
      end
      if (score_load) begin
         score_ff <= score_in;
      end
      if (finish) begin
         rsp_accepted_ff <= pool_status.accepted;
         rsp_found_ff    <= pool_status.found;
         rsp_key_ff      <= pool_status.key;
         rsp_db_ff       <= pool_status.db;
         rsp_score_ff    <= result_score;
         rsp_occ_ff      <= pool_status.occupancy;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.accepted   = rsp_accepted_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.best_key   = rsp_key_ff;
   assign rsp_chan.best_db    = rsp_db_ff;
   assign rsp_chan.best_score = rsp_score_ff;
   assign rsp_chan.occupancy  = rsp_occ_ff;

endmodule

### hdl/ecp_div.sv
// Restoring divider, one quotient bit per cycle, for the frequency decay.
// Depends on ecp_pkg for DIV_W.
module ecp_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ecp_pkg::DIV_W-1:0] dividend,
   input  logic [ecp_pkg::DIV_W-1:0] divisor,
   output logic                     done,
   output logic [ecp_pkg::DIV_W-1:0] quotient
);
   import ecp_pkg::*;

   localparam int COUNT_W = $clog2(DIV_W);
   localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(DIV_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W:0]     rem_shift;
   logic [DIV_W:0]     rem_diff;
   logic               fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor};
      fits      = rem_shift >= {1'b0, divisor};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIV_W-2:0], fits};
         rem_in   = fits ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
         count_in = count_ff + COUNT_W'(1);
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/ecp_pool.sv
// Sorted candidate pool: per-entry compare, then insert or take.
// Depends on ecp_pkg for widths and the command and status structs.
module ecp_pool #(
   parameter int POOL_DEPTH = ecp_pkg::POOL_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ecp_pkg::pool_cmd_type       cmd,
   input  logic [ecp_pkg::SCORE_W-1:0] new_score,
   input  logic [ecp_pkg::KEY_W-1:0]   new_key,
   input  logic [ecp_pkg::DB_W-1:0]    new_db,
   output ecp_pkg::pool_status_type    status
);
   import ecp_pkg::*;

   localparam int OCC_W = $clog2(POOL_DEPTH + 1);
   localparam int EXT_W = OCC_W + OCC_REPORT_W;

   logic [POOL_DEPTH-1:0] valid_ff, valid_in;
   logic [POOL_DEPTH-1:0] lt_ff, lt_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;

   logic [SCORE_W-1:0] score_ff [POOL_DEPTH];
   logic [SCORE_W-1:0] score_in [POOL_DEPTH];
   logic [KEY_W-1:0]   key_ff   [POOL_DEPTH];
   logic [KEY_W-1:0]   key_in   [POOL_DEPTH];
   logic [DB_W-1:0]    db_ff    [POOL_DEPTH];
   logic [DB_W-1:0]    db_in    [POOL_DEPTH];

   logic [SCORE_W-1:0] score_prev [POOL_DEPTH];
   logic [SCORE_W-1:0] score_next [POOL_DEPTH];
   logic [KEY_W-1:0]   key_prev   [POOL_DEPTH];
   logic [KEY_W-1:0]   key_next   [POOL_DEPTH];
   logic [DB_W-1:0]    db_prev    [POOL_DEPTH];
   logic [DB_W-1:0]    db_next    [POOL_DEPTH];

   logic [POOL_DEPTH-1:0] lt_prev, lt_next, valid_prev, valid_next, last;
   logic                  full, reject;
   logic [KEY_W-1:0]      take_key;
   logic [DB_W-1:0]       take_db;
   logic [SCORE_W-1:0]    take_score;
   logic [EXT_W-1:0]      occ_ext;

   always_comb begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
         lt_in[i] = valid_ff[i] && (score_ff[i] < new_score);
      end
   end

   assign lt_prev    = {lt_ff[POOL_DEPTH-2:0], 1'b1};
   assign lt_next    = {1'b0, lt_ff[POOL_DEPTH-1:1]};
   assign valid_prev = {valid_ff[POOL_DEPTH-2:0], 1'b0};
   assign valid_next = {1'b0, valid_ff[POOL_DEPTH-1:1]};
   assign last       = valid_ff & ~valid_next;
   assign full       = valid_ff[POOL_DEPTH-1];
   // Full pool and the offer scores no higher than the lowest entry.
   assign reject     = full && !lt_ff[0];

   always_comb begin
      score_prev[0]            = score_ff[0];
      key_prev[0]              = key_ff[0];
      db_prev[0]               = db_ff[0];
      score_next[POOL_DEPTH-1] = score_ff[POOL_DEPTH-1];
      key_next[POOL_DEPTH-1]   = key_ff[POOL_DEPTH-1];
      db_next[POOL_DEPTH-1]    = db_ff[POOL_DEPTH-1];
      for (int i = 1; i < POOL_DEPTH; i++) begin
         score_prev[i]   = score_ff[i-1];
         key_prev[i]     = key_ff[i-1];
         db_prev[i]      = db_ff[i-1];
         score_next[i-1] = score_ff[i];
         key_next[i-1]   = key_ff[i];
         db_next[i-1]    = db_ff[i];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      score_in = score_ff;
      key_in   = key_ff;
      db_in    = db_ff;
      if (cmd.insert && !reject) begin
         for (int i = 0; i < POOL_DEPTH; i++) begin
            if (!full) begin
               // Slot after the last lower score takes the item; the rest move up.
               if (lt_prev[i] && !lt_ff[i]) begin
                  valid_in[i] = 1'b1;
                  score_in[i] = new_score;
                  key_in[i]   = new_key;
                  db_in[i]    = new_db;
               end else if (!lt_prev[i]) begin
                  valid_in[i] = valid_prev[i];
                  score_in[i] = score_prev[i];
                  key_in[i]   = key_prev[i];
                  db_in[i]    = db_prev[i];
               end
            end else begin
               // Drop the lowest entry and move the lower ones down.
               if (lt_ff[i] && !lt_next[i]) begin
                  score_in[i] = new_score;
                  key_in[i]   = new_key;
                  db_in[i]    = new_db;
               end else if (lt_next[i]) begin
                  score_in[i] = score_next[i];
                  key_in[i]   = key_next[i];
                  db_in[i]    = db_next[i];
               end
            end
         end
         if (!full) begin
            occ_in = occ_ff + OCC_W'(1);
         end
      end
      if (cmd.take && valid_ff[0]) begin
         valid_in = valid_ff & ~last;
         occ_in   = occ_ff - OCC_W'(1);
      end
   end

   always_comb begin
      take_key   = '0;
      take_db    = '0;
      take_score = '0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
         take_key   = take_key   | ({KEY_W{last[i]}}   & key_ff[i]);
         take_db    = take_db    | ({DB_W{last[i]}}    & db_ff[i]);
         take_score = take_score | ({SCORE_W{last[i]}} & score_ff[i]);
      end
   end

   assign occ_ext = EXT_W'(occ_in);

   always_comb begin
      status.accepted  = cmd.insert && !reject;
      status.found     = cmd.take && valid_ff[0];
      status.key       = status.found ? take_key   : '0;
      status.db        = status.found ? take_db    : '0;
      status.score     = status.found ? take_score : '0;
      status.occupancy = occ_ext[OCC_REPORT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         lt_ff    <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         if (cmd.compare) begin
            lt_ff <= lt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      key_ff   <= key_in;
      db_ff    <= db_in;
   end

endmodule

### hdl/ecp_checker.sv
// Port-level checks for the eviction candidate pool, bound to the top level.
// Depends on ecp_pkg and on the top level's channel interfaces.
module ecp_checker #(
   parameter int POOL_DEPTH = ecp_pkg::POOL_DEPTH_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_accepted,
   input logic                             rsp_found,
   input logic [ecp_pkg::KEY_W-1:0]        rsp_key,
   input logic [ecp_pkg::DB_W-1:0]         rsp_db,
   input logic [ecp_pkg::SCORE_W-1:0]      rsp_score,
   input logic [ecp_pkg::OCC_REPORT_W-1:0] rsp_occupancy
);
   import ecp_pkg::*;

   // A stalled result stays valid and holds its score, key and occupancy.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_score) &&
                                  $stable(rsp_key) && $stable(rsp_occupancy))
      else $error("stalled result changed");

   // One item at a time: the sequencer leaves idle on every accepted item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in progress");

   // An offer that was stored never reports a removed entry.
   a_offer_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_found && rsp_key == '0 && rsp_db == '0)
      else $error("stored offer reports take fields");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (POOL_DEPTH >= 32) || (rsp_occupancy <= POOL_DEPTH))
      else $error("occupancy beyond pool depth");

endmodule

bind eviction_candidate_pool ecp_checker #(
   .POOL_DEPTH (POOL_DEPTH)
) u_ecp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_accepted  (rsp_chan.accepted),
   .rsp_found     (rsp_chan.found),
   .rsp_key       (rsp_chan.best_key),
   .rsp_db        (rsp_chan.best_db),
   .rsp_score     (rsp_chan.best_score),
   .rsp_occupancy (rsp_chan.occupancy)
);
